>>> hdl/mat_pkg.sv
// Shared types and constants for the MAC allowlist table.
package mat_pkg;

   localparam int PEER_SLOTS_DEF = 8;
   // Count field of CNT_W bits: counts up to 127 valid slots.
   localparam int CNT_W = 7;
   localparam int MAC_W = 48;
   localparam int DTYPE_W = 8;
   localparam int CSR_IDX_W = 2;

   // Request codes.
   localparam logic [2:0] REQ_ADD    = 3'd0;
   localparam logic [2:0] REQ_REMOVE = 3'd1;
   localparam logic [2:0] REQ_LOOKUP = 3'd2;
   localparam logic [2:0] REQ_FIRST  = 3'd3;
   localparam logic [2:0] REQ_CLEAR  = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_MAC    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_TYPE   = 2'd2;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [MAC_W-1:0]   mac;
      logic [DTYPE_W-1:0] peer_type;
   } req_word_type;

   typedef struct packed {
      logic               ok;
      logic [MAC_W-1:0]   result_mac;
      logic [DTYPE_W-1:0] result_type;
      logic [3:0]         peer_count;
   } rsp_word_type;

   // Operation carried by a token along the cell chain.
   typedef enum logic [2:0] {
      OP_ADD_SEARCH,
      OP_ADD_FILL,
      OP_REMOVE,
      OP_LOOKUP,
      OP_FIRST,
      OP_CLEAR,
      OP_NOP
   } pass_op_type;

   typedef struct packed {
      logic               live;
      pass_op_type        op;
      logic [MAC_W-1:0]   mac;
      logic [DTYPE_W-1:0] dev_type;
      logic               done;       // request already resolved upstream
      logic               ok;
      logic               free_seen;  // add search passed an empty slot
      logic [MAC_W-1:0]   rmac;
      logic [DTYPE_W-1:0] rtype;
      logic [CNT_W-1:0]   cnt;        // valid slots so far, after update
   } token_type;

endpackage

>>> hdl/mat_cell.sv
// One table slot: holds an entry and forwards the request token to the next slot.
module mat_cell (
   input  logic               clock,
   input  logic               reset,
   input  mat_pkg::token_type tok_in,
   output mat_pkg::token_type tok_out
);
   import mat_pkg::*;

   logic               valid_ff, valid_in;
   logic [MAC_W-1:0]   mac_ff, mac_in;
   logic [DTYPE_W-1:0] type_ff, type_in;
   token_type          tok_ff, tok_nx;

   logic mac_hit, type_hit;

   assign mac_hit  = valid_ff && (mac_ff == tok_in.mac);
   assign type_hit = valid_ff && (type_ff == tok_in.dev_type);

   always_comb begin
      valid_in = valid_ff;
      mac_in   = mac_ff;
      type_in  = type_ff;
      tok_nx   = tok_in;
      unique case (tok_in.op)
         OP_ADD_SEARCH: begin
            if (!tok_in.done && mac_hit) begin
               type_in     = tok_in.dev_type;
               tok_nx.done = 1'b1;
               tok_nx.ok   = 1'b1;
            end
            if (!valid_ff) begin
               tok_nx.free_seen = 1'b1;
            end
         end
         OP_ADD_FILL: begin
            if (!tok_in.done && !valid_ff) begin
               valid_in    = 1'b1;
               mac_in      = tok_in.mac;
               type_in     = tok_in.dev_type;
               tok_nx.done = 1'b1;
               tok_nx.ok   = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (!tok_in.done && mac_hit) begin
               valid_in    = 1'b0;
               mac_in      = '0;
               type_in     = '0;
               tok_nx.done = 1'b1;
               tok_nx.ok   = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (!tok_in.done && mac_hit) begin
               tok_nx.done  = 1'b1;
               tok_nx.ok    = 1'b1;
               tok_nx.rtype = type_ff;
            end
         end
         OP_FIRST: begin
            if (!tok_in.done && type_hit) begin
               tok_nx.done = 1'b1;
               tok_nx.ok   = 1'b1;
               tok_nx.rmac = mac_ff;
            end
         end
         OP_CLEAR: begin
            valid_in = 1'b0;
            mac_in   = '0;
            type_in  = '0;
         end
         default: begin
         end
      endcase
      tok_nx.cnt = tok_in.cnt + CNT_W'(valid_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (tok_in.live) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tok_in.live) begin
         mac_ff  <= mac_in;
         type_ff <= type_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.live <= 1'b0;
      end else begin
         tok_ff <= tok_nx;
      end
   end

   assign tok_out = tok_ff;

endmodule

>>> hdl/mac_allowlist_table.sv
// Top level of the MAC allowlist table: config registers, request launch and result staging.
//
// A table of PEER_SLOTS approved MAC addresses, each with a device type, built
// as a chain of slot cells. A request is launched as a token that walks the
// chain one cell per clock; each cell compares, updates its entry and adds its
// valid bit to the running peer count. The preset peer held in the csr
// registers is checked when the token is launched, so it takes priority over
// the slots for lookup and first-of-type. From acceptance a request passes
// the launch register, each slot cell, the hold register and then the output
// register; an add that has to fill a new slot walks the chain twice (once to
// look for an existing entry and a free slot, once to claim the lowest free
// slot). One request is in flight at a time; a finished word may wait in the
// output register while the next request runs. The user must write config
// only while idle; the block itself does not enforce it.
module mac_allowlist_table #(
   parameter int PEER_SLOTS = mat_pkg::PEER_SLOTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mat_pkg::req_word_type         req_word,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mat_pkg::rsp_word_type         rsp_word,
   // config write port
   input  logic                          csr_wr_en,
   input  logic [mat_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mat_pkg::MAC_W-1:0]     csr_wr_data
);
   import mat_pkg::*;

   // config registers
   logic               preset_enable_ff;
   logic [MAC_W-1:0]   preset_mac_ff;
   logic [DTYPE_W-1:0] preset_type_ff;
   logic               preset_active;

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_enable_ff <= 1'b0;
         preset_mac_ff    <= '0;
         preset_type_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PRESET_ENABLE: preset_enable_ff <= csr_wr_data[0];
            CSR_PRESET_MAC:    preset_mac_ff    <= csr_wr_data;
            CSR_PRESET_TYPE:   preset_type_ff   <= csr_wr_data[DTYPE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // zero preset MAC means no preset
   assign preset_active = preset_enable_ff && (preset_mac_ff != '0);

   // token chain: tok[0] is the launch register, tok[PEER_SLOTS] the chain end
   token_type tok [0:PEER_SLOTS];
   token_type launch_ff, launch_in, req_tok;

   logic busy_ff, busy_in;
   logic hold_valid_ff, hold_valid_in;
   rsp_word_type hold_ff, hold_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_ff;

   logic accept, relaunch, finish, rsp_load;
   token_type tok_end;
   logic [CNT_W:0] cnt_sum;

   assign req_stall = busy_ff || hold_valid_ff;
   assign accept    = req_valid && !req_stall;

   assign tok_end  = tok[PEER_SLOTS];
   // add found no entry but passed a free slot: walk again and claim it
   assign relaunch = tok_end.live && (tok_end.op == OP_ADD_SEARCH) &&
                     !tok_end.done && tok_end.free_seen;
   assign finish   = tok_end.live && !relaunch;

   // build the launch token; preset checks happen here
   always_comb begin
      req_tok           = '0;
      req_tok.live      = 1'b1;
      req_tok.mac       = req_word.mac;
      req_tok.dev_type  = req_word.peer_type;
      req_tok.op        = OP_NOP;
      req_tok.done      = 1'b1;
      unique case (req_word.req_type)
         REQ_ADD: begin
            req_tok.op   = OP_ADD_SEARCH;
            req_tok.done = (req_word.mac == '0);
         end
         REQ_REMOVE: begin
            req_tok.op   = OP_REMOVE;
            req_tok.done = 1'b0;
         end
         REQ_LOOKUP: begin
            req_tok.op = OP_LOOKUP;
            if (req_word.mac == '0) begin
               req_tok.done = 1'b1;
            end else if (preset_active && (preset_mac_ff == req_word.mac)) begin
               req_tok.done  = 1'b1;
               req_tok.ok    = 1'b1;
               req_tok.rtype = preset_type_ff;
            end else begin
               req_tok.done = 1'b0;
            end
         end
         REQ_FIRST: begin
            req_tok.op = OP_FIRST;
            if (preset_active && (preset_type_ff == req_word.peer_type)) begin
               req_tok.done = 1'b1;
               req_tok.ok   = 1'b1;
               req_tok.rmac = preset_mac_ff;
            end else begin
               req_tok.done = 1'b0;
            end
         end
         REQ_CLEAR: begin
            req_tok.op   = OP_CLEAR;
            req_tok.ok   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      launch_in = tok_end;
      priority if (accept) begin
         launch_in = req_tok;
      end else if (relaunch) begin
         launch_in.op        = OP_ADD_FILL;
         launch_in.done      = 1'b0;
         launch_in.ok        = 1'b0;
         launch_in.free_seen = 1'b0;
         launch_in.cnt       = '0;
      end else begin
         launch_in.live = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff.live <= 1'b0;
      end else begin
         launch_ff <= launch_in;
      end
   end

   assign tok[0] = launch_ff;

   genvar gi;
   generate
      for (gi = 0; gi < PEER_SLOTS; gi++) begin : g_cell
         mat_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (tok[gi]),
            .tok_out (tok[gi+1])
         );
      end
   endgenerate

   // final word from the chain end; count includes the preset, saturates at 15
   assign cnt_sum = {1'b0, tok_end.cnt} + (CNT_W+1)'(preset_active);

   always_comb begin
      hold_in.ok          = tok_end.ok;
      hold_in.result_mac  = tok_end.rmac;
      hold_in.result_type = tok_end.rtype;
      hold_in.peer_count  = (cnt_sum > (CNT_W+1)'(15)) ? 4'hF : cnt_sum[3:0];
   end

   assign rsp_load = hold_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end
      // hold is always empty when the chain finishes
      hold_valid_in = finish || (hold_valid_ff && !rsp_load);
      rsp_valid_in  = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         hold_ff <= hold_in;
      end
      if (rsp_load) begin
         rsp_ff <= hold_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule
